FILE: rtl/dde_pkg.sv
// Shared constants for the decimal digit emitter.
`timescale 1ns / 1ps
package dde_pkg;
    // Binary value width
    localparam int VALUE_W = 32;
    // Shift steps of one conversion
    localparam int SHIFT_STEPS = VALUE_W;
    // Character codes
    localparam logic [5:0] CH_SPACE = 6'd32;
    localparam logic [5:0] CH_ZERO = 6'd48;
    // Row bump applied when a column wraps
    localparam logic [7:0] ROW_RAISE = 8'd2;
    // Digit offset that triggers the add-3 correction
    localparam logic [3:0] BCD_ADJ_MIN = 4'd5;
    localparam logic [3:0] BCD_ADJ_ADD = 4'd3;
endpackage

FILE: rtl/dde_dabble.sv
// Iterative shift-add-3 binary to BCD converter, one bit per cycle.
`timescale 1ns / 1ps
module dde_dabble #(
    parameter int NDIG = 10
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [dde_pkg::VALUE_W-1:0] value,
    output logic                        done,
    output logic [NDIG-1:0][3:0]        bcd
);
    import dde_pkg::*;

    localparam int CNT_W = $clog2(SHIFT_STEPS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SHIFT_STEPS - 1);

    logic [VALUE_W-1:0]   bin_reg, bin_next;
    logic [NDIG-1:0][3:0] bcd_reg, bcd_next;
    logic [NDIG-1:0][3:0] adj;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;

    // Add-3 correction on every digit, then shift one binary bit in.
    // Digits beyond the top one are dropped, so the result is value mod 10^NDIG.
    always_comb begin
        for (int i = 0; i < NDIG; i++) begin
            adj[i] = (bcd_reg[i] >= BCD_ADJ_MIN) ? bcd_reg[i] + BCD_ADJ_ADD : bcd_reg[i];
        end
    end

    always_comb begin
        bin_next  = bin_reg;
        bcd_next  = bcd_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            bin_next  = value;
            bcd_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            bcd_next = (NDIG*4)'({adj, bin_reg[VALUE_W-1]});
            bin_next = {bin_reg[VALUE_W-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_LAST) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    assign done = done_reg;
    assign bcd  = bcd_reg;
endmodule

FILE: rtl/decimal_digit_emitter.sv
// Top level: converts a value to decimal and streams one character per digit.
// An item is taken only while idle; its value runs through the iterative BCD
// converter, then one character per cycle is emitted while the sink is ready.
// No new item is accepted until the last character of the current one is sent.
// A digit count of zero produces no characters and starts no conversion.
// Reset is synchronous, active low, and clears the sequencer and output valid.
`timescale 1ns / 1ps
module decimal_digit_emitter #(
    parameter int MAX_DIGITS    = 10,
    parameter int PANEL_COLUMNS = 128
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [31:0] value, [35:32] digit_count, [43:36] start_column,
    // [51:44] start_row, [59:52] font_height, [63:60] zero
    input  logic [63:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [5:0] char_code, [12:6] column, [20:13] row, [23:21] zero
    output logic [23:0] m_tdata,
    output logic        m_tlast
);
    import dde_pkg::*;

    localparam int IW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam logic [3:0] MAX_CNT = 4'(MAX_DIGITS);
    localparam logic [7:0] PANEL_LIM = 8'(PANEL_COLUMNS);

    typedef enum logic [1:0] {ST_IDLE, ST_CONV, ST_EMIT} state_t;

    state_t state_reg, state_next;

    logic [VALUE_W-1:0] in_value;
    logic [3:0]         in_count;
    logic [3:0]         sat_count;
    logic [7:0]         in_col;
    logic [7:0]         in_row;
    logic [7:0]         in_font;

    logic [IW-1:0] pos_reg, pos_next;
    logic [7:0]    col_reg, col_next;
    logic [7:0]    row_reg, row_next;
    logic [6:0]    step_reg, step_next;
    logic          lead_reg, lead_next;
    logic          more_reg, more_next;

    logic          m_valid_reg, m_valid_next;
    logic [5:0]    m_char_reg, m_char_next;
    logic [6:0]    m_col_reg, m_col_next;
    logic [7:0]    m_row_reg, m_row_next;
    logic          m_last_reg, m_last_next;

    logic                       conv_start;
    logic                       conv_done;
    logic [MAX_DIGITS-1:0][3:0] conv_bcd;

    logic [3:0] cur_digit;
    logic       cur_last;
    logic       cur_wrap;
    logic       cur_blank;
    logic       out_free;

    // Input field unpacking
    assign in_value  = s_tdata[31:0];
    assign in_count  = s_tdata[35:32];
    assign in_col    = s_tdata[43:36];
    assign in_row    = s_tdata[51:44];
    assign in_font   = s_tdata[59:52];
    assign sat_count = (in_count > MAX_CNT) ? MAX_CNT : in_count;

    assign s_tready   = (state_reg == ST_IDLE);
    assign conv_start = s_tvalid && s_tready && (sat_count != 4'd0);

    dde_dabble #(
        .NDIG (MAX_DIGITS)
    ) u_dabble (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (conv_start),
        .value   (in_value),
        .done    (conv_done),
        .bcd     (conv_bcd)
    );

    // Current character: digit, blanking and column wrap
    assign cur_digit = conv_bcd[pos_reg];
    assign cur_last  = (pos_reg == '0);
    assign cur_wrap  = (col_reg >= PANEL_LIM);
    assign cur_blank = !lead_reg && !cur_last && (cur_digit == 4'd0);
    assign out_free  = !m_valid_reg || m_tready;

    // Sequencer
    always_comb begin
        state_next   = state_reg;
        pos_next     = pos_reg;
        col_next     = col_reg;
        row_next     = row_reg;
        step_next    = step_reg;
        lead_next    = lead_reg;
        more_next    = more_reg;
        m_valid_next = m_valid_reg;
        m_char_next  = m_char_reg;
        m_col_next   = m_col_reg;
        m_row_next   = m_row_reg;
        m_last_next  = m_last_reg;
        case (state_reg)
            ST_IDLE: begin
                if (conv_start) begin
                    pos_next   = IW'(sat_count - 4'd1);
                    col_next   = in_col;
                    row_next   = in_row;
                    step_next  = in_font[7:1];
                    lead_next  = 1'b0;
                    more_next  = 1'b1;
                    state_next = ST_CONV;
                end
            end
            ST_CONV: begin
                if (conv_done) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    if (more_reg) begin
                        m_valid_next = 1'b1;
                        m_char_next  = cur_blank ? CH_SPACE : CH_ZERO + {2'b00, cur_digit};
                        m_col_next   = cur_wrap ? 7'd0 : col_reg[6:0];
                        m_row_next   = cur_wrap ? row_reg + ROW_RAISE : row_reg;
                        m_last_next  = cur_last;
                        lead_next    = lead_reg || !cur_blank;
                        col_next     = col_reg + {1'b0, step_reg};
                        pos_next     = pos_reg - 1'b1;
                        more_next    = !cur_last;
                    end else begin
                        m_valid_next = 1'b0;
                        state_next   = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            more_reg    <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            more_reg    <= more_next;
        end
        pos_reg    <= pos_next;
        col_reg    <= col_next;
        row_reg    <= row_next;
        step_reg   <= step_next;
        lead_reg   <= lead_next;
        m_char_reg <= m_char_next;
        m_col_reg  <= m_col_next;
        m_row_reg  <= m_row_next;
        m_last_reg <= m_last_next;
    end

    // Output packing
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'b000, m_row_reg, m_col_reg, m_char_reg};
    assign m_tlast  = m_last_reg;

`ifndef SYNTH
    // No new input is taken while a character is pending
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(m_tvalid && s_tready))
        else $error("input accepted while output pending");

    // Output characters are a space or a decimal digit
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[5:0] == CH_SPACE) ||
            ((m_tdata[5:0] >= CH_ZERO) && (m_tdata[5:0] <= CH_ZERO + 6'd9)))
        else $error("bad character code");

    // The final character is never blanked
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> (m_tdata[5:0] != CH_SPACE))
        else $error("last character blanked");

    // A nonzero count starts a conversion and drops ready
    assert property (@(posedge aclk) disable iff (!aresetn)
        conv_start |=> !s_tready)
        else $error("ready held during conversion");
`endif
endmodule
